FILE: rtl/calendar_clock_counter_defines.svh
// Assertion macros for the clock-calendar RTL.
// The enclosing module must provide clk_i and rst_ni.
`ifndef CALENDAR_CLOCK_COUNTER_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define CCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define CCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ccc_pkg.sv
package ccc_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_ADJUST  = 3'd1,
    KIND_LOAD    = 3'd2,
    KIND_SET     = 3'd3,
    KIND_CONFIRM = 3'd4
  } kind_e;

  // Adjust targets
  typedef enum logic [1:0] {
    COMP_HOUR   = 2'd0,
    COMP_MINUTE = 2'd1,
    COMP_AMPM   = 2'd2
  } comp_e;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
  localparam logic [4:0] HALF_DAY         = 5'd12;
  localparam logic [3:0] MONTHS_PER_YEAR  = 4'd12;

  localparam logic [5:0]  RST_MINUTE = 6'd0;
  localparam logic [4:0]  RST_HOUR   = 5'd12;
  localparam logic [4:0]  RST_DAY    = 5'd1;
  localparam logic [3:0]  RST_MONTH  = 4'd1;
  localparam logic [11:0] RST_YEAR   = 12'd2000;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [4:0] LEAP_FEB_LEN = 5'd29;
  localparam logic [4:0] MAX_MONTH_LEN = 5'd31;

  // Reciprocal of 25 in 16 fractional bits, exact for all 12-bit years
  localparam int unsigned DIV25_SHIFT = 16;
  localparam int unsigned DIV25       = 25;
  localparam logic [11:0] DIV25_MUL   = 12'((1 << DIV25_SHIFT) / DIV25 + 1);

  // Timekeeping state
  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;    // 0..23
    logic        pm;
    logic [4:0]  day;
    logic [3:0]  month;   // 1..12
    logic [11:0] year;
    logic        run;
    logic        setting;
  } clk_state_t;

  // One input item
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  component;
    logic        step_up;
    logic [11:0] new_year;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
  } item_t;

  // Gregorian leap year: divisible by 4 and not by 100, or by 400.
  // 100 = 4 * 25 and 400 = 16 * 25, so only divisibility by 25 needs a multiply.
  function automatic logic is_leap(input logic [11:0] y);
    logic [23:0] prod;
    logic [7:0]  q25;
    logic        by25;
    prod = 24'(y) * 24'(DIV25_MUL);
    q25  = prod[23:16];
    by25 = (12'(q25) * 12'(DIV25)) == y;
    return (y[1:0] == 2'b00) && (!by25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if (m == 4'd0 || m > MONTHS_PER_YEAR) begin
      return MAX_MONTH_LEN;
    end else if (m == 4'd2 && leap) begin
      return LEAP_FEB_LEN;
    end
    return MONTH_LEN[idx];
  endfunction

  // Twelve-hour dial: hour zero shows as 12
  function automatic logic [3:0] dial_hour(input logic [4:0] h);
    if (h == 5'd0) begin
      return 4'(HALF_DAY);
    end else if (h > HALF_DAY) begin
      return 4'(h - HALF_DAY);
    end
    return 4'(h);
  endfunction

endpackage

FILE: rtl/ccc_step.sv
module ccc_step (
  input  ccc_pkg::clk_state_t cur_i,
  input  ccc_pkg::item_t      item_i,
  output ccc_pkg::clk_state_t nxt_o,
  output logic                hour_passed_o
);
  import ccc_pkg::*;

  logic [4:0] hour_inc;
  logic [4:0] hour_dec;
  logic [5:0] minute_inc;
  logic [5:0] minute_dec;
  logic [5:0] day_inc;
  logic [4:0] month_days;

  // Wrapping hour and minute steps (increments shared by tick and adjust), day step, month length
  assign hour_inc   = (cur_i.hour >= HOURS_PER_DAY - 5'd1) ? 5'd0 : cur_i.hour + 5'd1;
  assign hour_dec   = (cur_i.hour == 5'd0) ? HOURS_PER_DAY - 5'd1 : cur_i.hour - 5'd1;
  assign minute_inc = (cur_i.minute >= MINUTES_PER_HOUR - 6'd1) ? 6'd0 : cur_i.minute + 6'd1;
  assign minute_dec = (cur_i.minute == 6'd0) ? MINUTES_PER_HOUR - 6'd1 : cur_i.minute - 6'd1;
  assign day_inc    = {1'b0, cur_i.day} + 6'd1;
  assign month_days = days_in_month(cur_i.month, is_leap(cur_i.year));

  // Next state for one item
  always_comb begin
    nxt_o         = cur_i;
    hour_passed_o = 1'b0;
    case (item_i.kind)
      KIND_TICK: begin
        if (cur_i.run) begin
          nxt_o.minute = minute_inc;
          if (cur_i.minute >= MINUTES_PER_HOUR - 6'd1) begin
            hour_passed_o = 1'b1;
            nxt_o.hour    = hour_inc;
            nxt_o.pm      = hour_inc >= HALF_DAY;
            // midnight: advance the date
            if (hour_inc == 5'd0) begin
              if (day_inc > {1'b0, month_days}) begin
                nxt_o.day = 5'd1;
                if (cur_i.month >= MONTHS_PER_YEAR) begin
                  nxt_o.month = 4'd1;
                  nxt_o.year  = cur_i.year + 12'd1;
                end else begin
                  nxt_o.month = cur_i.month + 4'd1;
                end
              end else begin
                nxt_o.day = day_inc[4:0];
              end
            end
          end
        end
      end
      KIND_ADJUST: begin
        case (item_i.component)
          COMP_HOUR:   nxt_o.hour   = item_i.step_up ? hour_inc : hour_dec;
          COMP_MINUTE: nxt_o.minute = item_i.step_up ? minute_inc : minute_dec;
          COMP_AMPM:   nxt_o.pm     = ~cur_i.pm;
          default:     ;
        endcase
      end
      KIND_LOAD: begin
        nxt_o.year  = item_i.new_year;
        nxt_o.month = (item_i.new_month == 4'd0) ? 4'd1 :
                      (item_i.new_month > MONTHS_PER_YEAR) ? MONTHS_PER_YEAR :
                      item_i.new_month;
        nxt_o.day   = (item_i.new_day == 5'd0) ? 5'd1 : item_i.new_day;
      end
      KIND_SET: begin
        nxt_o.setting = 1'b1;
        nxt_o.run     = 1'b0;
      end
      KIND_CONFIRM: begin
        if (cur_i.setting) begin
          nxt_o.setting = 1'b0;
          nxt_o.run     = 1'b1;
          // move the hour into the half of the day that AM/PM selects
          if (cur_i.pm && cur_i.hour < HALF_DAY) begin
            nxt_o.hour = cur_i.hour + HALF_DAY;
          end else if (!cur_i.pm && cur_i.hour >= HALF_DAY) begin
            nxt_o.hour = cur_i.hour - HALF_DAY;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/calendar_clock_counter.sv
// Minute-tick clock-calendar with a stream interface. Each input item (a tick, an
// hour/minute/AM-PM adjust, a date load, begin-setting or confirm) updates the time
// and date in the cycle it is accepted, and exactly one result item follows carrying
// the new twelve-hour time, date, mode flags and an hour-change pulse. Ticks count
// only while running; setting mode stops the count and confirm restarts it. One item
// is accepted per cycle and its result is offered in the next cycle: the whole update
// is a single pass of logic between the state registers and the output register, and
// input ready is held low only while a result is waiting on a stalled output.
`include "calendar_clock_counter_defines.svh"

module calendar_clock_counter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // component[1:0], step_up[2], new_year[14:3], new_month[18:15], new_day[23:19]
  input  logic [ccc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind[2:0]
  input  logic [ccc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // display_hour[3:0], minute_now[9:4], pm_flag[10], day_now[15:11],
  // month_now[19:16], year_now[31:20], running[32], setting_mode[33],
  // hour_passed[34], zero fill [39:35]
  output logic [ccc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import ccc_pkg::*;

  clk_state_t               state_q, state_d;
  item_t                    item;
  logic                     hour_passed;
  logic                     accept;
  logic                     out_valid_q;
  logic [OUT_TDATA_W-1:0]   out_data_q, out_data_d;
  logic                     stalled;
  logic                     time_ok;
  logic                     month_ok;
  logic                     non_tick;
  logic                     pulse_shown;

  // Unpack the incoming item
  assign item.kind      = s_axis_tuser;
  assign item.component = s_axis_tdata[1:0];
  assign item.step_up   = s_axis_tdata[2];
  assign item.new_year  = s_axis_tdata[14:3];
  assign item.new_month = s_axis_tdata[18:15];
  assign item.new_day   = s_axis_tdata[23:19];

  ccc_step u_step (
    .cur_i         (state_q),
    .item_i        (item),
    .nxt_o         (state_d),
    .hour_passed_o (hour_passed)
  );

  // Take an item unless a result is stuck on the output
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Result packing
  assign out_data_d = {5'b0, hour_passed, state_d.setting, state_d.run, state_d.year,
                       state_d.month, state_d.day, state_d.pm, state_d.minute,
                       dial_hour(state_d.hour)};

  // Clock-calendar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.minute  <= RST_MINUTE;
      state_q.hour    <= RST_HOUR;
      state_q.pm      <= 1'b0;
      state_q.day     <= RST_DAY;
      state_q.month   <= RST_MONTH;
      state_q.year    <= RST_YEAR;
      state_q.run     <= 1'b0;
      state_q.setting <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Terms used by the checks
  assign stalled     = out_valid_q && !m_axis_tready;
  assign time_ok     = state_q.hour < HOURS_PER_DAY && state_q.minute < MINUTES_PER_HOUR;
  assign month_ok    = state_q.month != 4'd0 && state_q.month <= MONTHS_PER_YEAR;
  assign non_tick    = accept && item.kind != KIND_TICK;
  assign pulse_shown = out_valid_q && out_data_q[34];

  // Checks
  `CCC_ASSERT(a_mode_excl, !(state_q.run && state_q.setting), "running while setting")
  `CCC_ASSERT(a_time_range, time_ok, "time out of range")
  `CCC_ASSERT(a_month_range, month_ok, "month out of range")
  `CCC_ASSERT(a_stall_blocks, !(stalled && s_axis_tready), "item taken over a stalled result")
  `CCC_ASSERT_NEXT(a_pulse_tick, non_tick, !pulse_shown, "hour pulse without tick")
  `CCC_ASSERT(a_pulse_min, !(pulse_shown && out_data_q[9:4] != 6'd0), "hour pulse off the hour")

endmodule

FILE: test/tb_calendar_clock_counter.sv
`timescale 1ns / 1ps

module tb_calendar_clock_counter;
  import ccc_pkg::*;

  // Codes outside the defined kinds and adjust targets
  localparam logic [2:0] KIND_RESERVED  = 3'd5;
  localparam logic [2:0] KIND_LAST_CODE = 3'd7;
  localparam logic [1:0] COMP_RESERVED  = 2'd3;

  localparam int LAST_MINUTE  = 59;
  localparam int LAST_HOUR    = 23;
  localparam int NOON         = 12;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD    = 48;
  localparam int STALL_LIMIT  = 500;

  localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // Result fields, last field in the lowest bits
  typedef struct packed {
    logic        hour_passed;
    logic        setting_mode;
    logic        running;
    logic [11:0] year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic        pm_flag;
    logic [5:0]  minute_now;
    logic [3:0]  display_hour;
  } reading_t;

  localparam int READING_W = $bits(reading_t);

  typedef struct {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic        pm;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic        run;
    logic        setting;
  } calendar_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  calendar_t cal = '{minute: 6'd0, hour: 5'd12, pm: 1'b0, day: 5'd1, month: 4'd1,
                     year: 12'd2000, run: 1'b0, setting: 1'b0};
  reading_t  expected_readings [$];

  int tx_gap_max      = 8;
  int rx_gap_max      = 8;
  bit long_hold_req   = 1'b0;
  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int hour_changes    = 0;
  int month_changes   = 0;
  int year_changes    = 0;
  int unsigned idle_cycles = 0;

  calendar_clock_counter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic leap_year(input logic [11:0] yr);
    int unsigned v;
    v = yr;
    return (v % 4 == 0) && ((v % 100 != 0) || (v % 400 == 0));
  endfunction

  function automatic int month_days(input logic [3:0] mo, input logic [11:0] yr);
    if (mo == 4'd0 || mo > 4'd12) begin
      return 31;
    end else if (mo == 4'd2 && leap_year(yr)) begin
      return 29;
    end
    return DAYS_PER_MONTH[mo - 1];
  endfunction

  // Advance the calendar by one accepted item and return the reading it shows
  function automatic reading_t apply_item(input logic [2:0] kind,
                                          input logic [IN_TDATA_W-1:0] data);
    logic [1:0]  comp;
    logic        up;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic        rolled;
    reading_t    r;
    comp   = data[1:0];
    up     = data[2];
    yr     = data[14:3];
    mo     = data[18:15];
    dy     = data[23:19];
    rolled = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (cal.run) begin
          if (cal.minute >= LAST_MINUTE) begin
            rolled     = 1'b1;
            cal.minute = '0;
            cal.hour   = (cal.hour == LAST_HOUR) ? 5'd0 : cal.hour + 5'd1;
            cal.pm     = (cal.hour >= NOON);
            // midnight: next day, possibly next month and year
            if (cal.hour == 5'd0) begin
              if (cal.day >= month_days(cal.month, cal.year)) begin
                cal.day = 5'd1;
                month_changes++;
                if (cal.month >= 4'd12) begin
                  cal.month = 4'd1;
                  cal.year  = cal.year + 12'd1;
                  year_changes++;
                end else begin
                  cal.month = cal.month + 4'd1;
                end
              end else begin
                cal.day = cal.day + 5'd1;
              end
            end
          end else begin
            cal.minute = cal.minute + 6'd1;
          end
        end
      end
      KIND_ADJUST: begin
        case (comp)
          COMP_HOUR: begin
            if (up) cal.hour = (cal.hour == LAST_HOUR) ? 5'd0 : cal.hour + 5'd1;
            else cal.hour = (cal.hour == 5'd0) ? 5'(LAST_HOUR) : cal.hour - 5'd1;
          end
          COMP_MINUTE: begin
            if (up) cal.minute = (cal.minute == LAST_MINUTE) ? 6'd0 : cal.minute + 6'd1;
            else cal.minute = (cal.minute == 6'd0) ? 6'(LAST_MINUTE) : cal.minute - 6'd1;
          end
          COMP_AMPM: cal.pm = ~cal.pm;
          default: ;
        endcase
      end
      KIND_LOAD: begin
        cal.year  = yr;
        cal.month = (mo == 4'd0) ? 4'd1 : ((mo > 4'd12) ? 4'd12 : mo);
        cal.day   = (dy == 5'd0) ? 5'd1 : dy;
      end
      KIND_SET: begin
        cal.setting = 1'b1;
        cal.run     = 1'b0;
      end
      KIND_CONFIRM: begin
        if (cal.setting) begin
          cal.setting = 1'b0;
          cal.run     = 1'b1;
          if (cal.pm && cal.hour < NOON) cal.hour = cal.hour + 5'(NOON);
          else if (!cal.pm && cal.hour >= NOON) cal.hour = cal.hour - 5'(NOON);
        end
      end
      default: ;
    endcase
    hour_changes += rolled;
    r.display_hour = (cal.hour == 5'd0) ? 4'(NOON) :
                     ((cal.hour > NOON) ? 4'(cal.hour - NOON) : 4'(cal.hour));
    r.minute_now   = cal.minute;
    r.pm_flag      = cal.pm;
    r.day_now      = cal.day;
    r.month_now    = cal.month;
    r.year_now     = cal.year;
    r.running      = cal.run;
    r.setting_mode = cal.setting;
    r.hour_passed  = rolled;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Predict on every input item, check every result item against the oldest prediction
  always @(posedge clk_i) begin : result_checker
    reading_t got;
    reading_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = reading_t'(m_axis_tdata[READING_W-1:0]);
      results_checked++;
      if (expected_readings.size() == 0) begin
        $display("%0t ns: result mismatch, expected none, actual tdata %h", $time,
                 m_axis_tdata);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("display_hour", want.display_hour, got.display_hour);
        check_field("minute_now", want.minute_now, got.minute_now);
        check_field("pm_flag", want.pm_flag, got.pm_flag);
        check_field("day_now", want.day_now, got.day_now);
        check_field("month_now", want.month_now, got.month_now);
        check_field("year_now", want.year_now, got.year_now);
        check_field("running", want.running, got.running);
        check_field("setting_mode", want.setting_mode, got.setting_mode);
        check_field("hour_passed", want.hour_passed, got.hour_passed);
        check_field("zero fill", 0, m_axis_tdata[OUT_TDATA_W-1:READING_W]);
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      expected_readings.push_back(apply_item(s_axis_tuser, s_axis_tdata));
    end
  end

  // Result sink: random stalls per item, and a long hold-off on request
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end
      stall = $urandom_range(0, rx_gap_max);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Watchdog on cycles where neither side moves an item
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t ns: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] kind, input logic [1:0] comp, input logic up,
                           input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {dy, mo, yr, up, comp};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind <= KIND_CONFIRM) items_sent++;
  endtask

  // Unused fields carry random values
  task automatic send_kind(input logic [2:0] kind);
    send_item(kind, 2'($urandom), 1'($urandom), 12'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic send_adjust(input logic [1:0] comp, input logic up);
    send_item(KIND_ADJUST, comp, up, 12'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic send_load(input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy);
    send_item(KIND_LOAD, 2'($urandom), 1'($urandom), yr, mo, dy);
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_readings.size() != 0);
  endtask

  // Step hour and minute to a target by the shortest way round
  task automatic steer_time(input int hr, input int mn);
    int diff;
    drain_results();
    diff = (hr - int'(cal.hour) + 24) % 24;
    if (diff <= 12) repeat (diff) send_adjust(COMP_HOUR, 1'b1);
    else repeat (24 - diff) send_adjust(COMP_HOUR, 1'b0);
    diff = (mn - int'(cal.minute) + 60) % 60;
    if (diff <= 30) repeat (diff) send_adjust(COMP_MINUTE, 1'b1);
    else repeat (60 - diff) send_adjust(COMP_MINUTE, 1'b0);
  endtask

  // Ticks before the first confirm change nothing; reserved kinds are ignored
  task automatic test_stopped_and_unknown();
    send_kind(KIND_TICK);
    send_kind(KIND_RESERVED);
    send_kind(KIND_LAST_CODE);
  endtask

  // Setting mode, AM/PM toggle, reserved target, confirm into PM half, stray confirm
  task automatic test_time_setting();
    send_load(12'hfff, 4'd12, 5'd31);
    send_kind(KIND_SET);
    send_adjust(COMP_HOUR, 1'b0);
    send_adjust(COMP_AMPM, 1'b1);
    send_adjust(COMP_RESERVED, 1'b1);
    send_kind(KIND_CONFIRM);
    send_kind(KIND_CONFIRM);
  endtask

  // Minute wraps both ways, then midnight on the last day of year 4095
  task automatic test_year_wrap();
    send_adjust(COMP_MINUTE, 1'b0);
    send_adjust(COMP_MINUTE, 1'b1);
    send_adjust(COMP_MINUTE, 1'b0);
    send_kind(KIND_TICK);
  endtask

  // Month and day saturation, hour wrap downwards, end of February in 1900
  task automatic test_load_limits();
    send_load(12'd0, 4'd0, 5'd31);
    send_load(12'd1900, 4'd15, 5'd0);
    send_load(12'd1900, 4'd2, 5'd28);
    send_adjust(COMP_HOUR, 1'b0);
    send_adjust(COMP_MINUTE, 1'b0);
    send_kind(KIND_TICK);
  endtask

  // Confirm into AM half, then the hour rolls to noon and PM comes on
  task automatic test_noon_rollover();
    send_adjust(COMP_HOUR, 1'b0);
    send_kind(KIND_SET);
    send_kind(KIND_CONFIRM);
    send_adjust(COMP_MINUTE, 1'b0);
    send_kind(KIND_TICK);
  endtask

  // Output held off while items keep coming, then the sender waits for all results
  task automatic test_output_backpressure();
    tx_gap_max    = 0;
    long_hold_req = 1'b1;
    repeat (16) send_kind(KIND_TICK);
    drain_results();
    tx_gap_max = 8;
  endtask

  task automatic test_random_traffic();
    int          start;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      case ($urandom_range(0, 9))
        // date near a month end, time just before midnight or noon, then ticks
        0, 1, 2: begin
          drain_results();
          if (!cal.run) begin
            send_kind(KIND_SET);
            send_kind(KIND_CONFIRM);
          end
          case ($urandom_range(0, 3))
            0: yr = 12'($urandom);
            1: yr = 12'($urandom_range(0, 10) * 400);
            2: yr = 12'($urandom_range(0, 40) * 100);
            default: yr = 12'($urandom_range(0, 1023) * 4);
          endcase
          if ($urandom_range(0, 2) == 0) mo = 4'($urandom);
          else if ($urandom_range(0, 1) == 0) mo = 4'd2;
          else mo = 4'($urandom_range(1, 12));
          if ($urandom_range(0, 3) == 0) dy = 5'($urandom);
          else dy = 5'(month_days(mo, yr) - $urandom_range(0, 1));
          send_load(yr, mo, dy);
          steer_time(($urandom_range(0, 3) == 0) ? NOON - 1 : LAST_HOUR, LAST_MINUTE);
          repeat ($urandom_range(1, 4)) send_kind(KIND_TICK);
        end
        // plain counting with the odd adjust
        3, 4, 5: begin
          repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 9) == 0) send_adjust(2'($urandom), 1'($urandom));
            else send_kind(KIND_TICK);
          end
        end
        // a setting session
        6: begin
          send_kind(KIND_SET);
          repeat ($urandom_range(1, 5)) send_adjust(2'($urandom), 1'($urandom));
          if ($urandom_range(0, 4) != 0) send_kind(KIND_CONFIRM);
        end
        // anything at all, reserved codes included
        7, 8: begin
          repeat ($urandom_range(1, 8)) begin
            send_item(3'($urandom_range(0, KIND_LAST_CODE)), 2'($urandom), 1'($urandom),
                      12'($urandom), 4'($urandom), 5'($urandom));
          end
        end
        default: begin
          send_load(12'($urandom), 4'($urandom), 5'($urandom));
          repeat ($urandom_range(0, 5)) send_kind(KIND_TICK);
        end
      endcase
    end
  endtask

  initial begin : test_sequence
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_stopped_and_unknown();
    test_time_setting();
    test_year_wrap();
    test_load_limits();
    test_noon_rollover();
    test_output_backpressure();
    test_random_traffic();
    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results under random stalls on both sides",
             items_sent, results_checked);
    $display("Predicted %0d hour changes, %0d month changes and %0d year changes",
             hour_changes, month_changes, year_changes);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
